// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the address syntax checker.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define ESC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ESC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/esc_pkg.sv
// Shared types, constants and the character class function of the checker.
// Depends on nothing.
package esc_pkg;

    localparam int MAX_LEN_DEF = 128;

    localparam logic [7:0] CH_AT  = 8'h40;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_UND = 8'h5F;
    localparam logic [7:0] CH_DSH = 8'h2D;

    typedef logic [7:0] char_t;

    // One character held in the input register, with its valid and last flags.
    typedef struct packed {
        logic  valid;
        char_t ch;
        logic  last;
    } stage_t;

    // True for letters, digits, underscore, dash and dot.
    function automatic logic is_allowed(input char_t c);
        logic ok;
        begin
            ok = ((c >= 8'h61) && (c <= 8'h7A)) ||
                 ((c >= 8'h41) && (c <= 8'h5A)) ||
                 ((c >= 8'h30) && (c <= 8'h39)) ||
                 (c == CH_UND) || (c == CH_DSH) || (c == CH_DOT);
            return ok;
        end
    endfunction

endpackage

// File: rtl/esc_char_if.sv
// Channel that carries one address character per item.
// Depends on esc_pkg.
interface esc_char_if;
    logic          valid;
    logic          ready;
    esc_pkg::char_t ch;
    logic          last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

// File: rtl/esc_res_if.sv
// Channel that carries one valid flag per completed address.
// Depends on nothing.
interface esc_res_if;
    logic valid;
    logic ready;
    logic valid_res;

    modport source (output valid, output valid_res, input ready);
    modport sink   (input valid, input valid_res, output ready);
endinterface

// File: rtl/esc_in_stage.sv
// Input register of the checker: takes one character item per cycle unless its held item stalls.
// Depends on esc_pkg and esc_char_if.
module esc_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    esc_char_if.sink        char_in,
    input  logic            adv,
    output esc_pkg::stage_t stage
);
    import esc_pkg::*;

    logic  valid_reg;
    char_t ch_reg;
    logic  last_reg;

    // The register may load when empty or when its item moves on this cycle.
    assign char_in.ready = !valid_reg || adv;

    // Valid flag of the held item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (char_in.ready)
        begin
            valid_reg <= char_in.valid;
        end
    end

    // Payload of the held item.
    always_ff @(posedge clk)
    begin
        if (char_in.ready && char_in.valid)
        begin
            ch_reg   <= char_in.ch;
            last_reg <= char_in.last;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.ch    = ch_reg;
    assign stage.last  = last_reg;
endmodule

// File: rtl/esc_rules.sv
// Rule state of the checker and the result register.
// Depends on esc_pkg and esc_res_if.
module esc_rules #(
    parameter int MAX_LEN = esc_pkg::MAX_LEN_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  esc_pkg::stage_t stage,
    output logic            adv,
    esc_res_if.source       res_out
);
    import esc_pkg::*;

    // The count saturates one above the longest legal address.
    localparam int CNT_W = $clog2(MAX_LEN + 2);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_LEN + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic seen_at_reg, seen_at_next;
    logic nonempty_reg, nonempty_next;
    logic prev_dot_reg, prev_dot_next;
    logic dom_dot_reg, dom_dot_next;
    logic failed_reg, failed_next;
    logic res_valid_reg;
    logic valid_res_reg;
    logic ok;

    // A final character needs the result register free; others always move.
    assign adv = stage.valid && (!stage.last || !res_valid_reg || res_out.ready);

    // Flag update for one character.
    always_comb
    begin
        count_next    = (count_reg == CNT_SAT) ? count_reg : count_reg + CNT_W'(1);
        seen_at_next  = seen_at_reg;
        nonempty_next = nonempty_reg;
        prev_dot_next = prev_dot_reg;
        dom_dot_next  = dom_dot_reg;
        failed_next   = failed_reg;
        if ((stage.ch == CH_AT) && !seen_at_reg)
        begin
            // The name part must be nonempty and must not end with a dot.
            if (!nonempty_reg || prev_dot_reg)
            begin
                failed_next = 1'b1;
            end
            seen_at_next  = 1'b1;
            nonempty_next = 1'b0;
            prev_dot_next = 1'b0;
        end
        else if (!is_allowed(stage.ch))
        begin
            failed_next   = 1'b1;
            nonempty_next = 1'b1;
            prev_dot_next = 1'b0;
        end
        else if (stage.ch == CH_DOT)
        begin
            // A dot that opens a part or follows another dot breaks a rule.
            if (!nonempty_reg || prev_dot_reg)
            begin
                failed_next = 1'b1;
            end
            prev_dot_next = 1'b1;
            nonempty_next = 1'b1;
            if (seen_at_reg)
            begin
                dom_dot_next = 1'b1;
            end
        end
        else
        begin
            prev_dot_next = 1'b0;
            nonempty_next = 1'b1;
        end
        ok = !failed_next && seen_at_next && nonempty_next && !prev_dot_next &&
             dom_dot_next && (count_next != CNT_SAT);
    end

    // Rule state: updated per character, cleared after each final character.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            seen_at_reg  <= 1'b0;
            nonempty_reg <= 1'b0;
            prev_dot_reg <= 1'b0;
            dom_dot_reg  <= 1'b0;
            failed_reg   <= 1'b0;
        end
        else if (adv)
        begin
            if (stage.last)
            begin
                count_reg    <= '0;
                seen_at_reg  <= 1'b0;
                nonempty_reg <= 1'b0;
                prev_dot_reg <= 1'b0;
                dom_dot_reg  <= 1'b0;
                failed_reg   <= 1'b0;
            end
            else
            begin
                count_reg    <= count_next;
                seen_at_reg  <= seen_at_next;
                nonempty_reg <= nonempty_next;
                prev_dot_reg <= prev_dot_next;
                dom_dot_reg  <= dom_dot_next;
                failed_reg   <= failed_next;
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv && stage.last)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_out.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (adv && stage.last)
        begin
            valid_res_reg <= ok;
        end
    end

    assign res_out.valid     = res_valid_reg;
    assign res_out.valid_res = valid_res_reg;
endmodule

// File: rtl/email_syntax_checker_core.sv
// Address syntax checker: one character item in per cycle while no final
// character waits on res_out, one flag out per address. Usage:
//   char_in carries ch (8-bit ASCII) and last, which marks the final
//   character. res_out carries valid_res, one item per address.
//   Both channels move an item when valid and ready are high at a clock edge.
//   The flag for an address is registered: its final character passes the
//   input register, and the result register loads when it moves on from
//   there (a final character moves only when the result register is free).
//   Throughput: one character per cycle while res_out takes results, set by
//   the single input register feeding the rules; addresses may follow with no gap.
//   Reset (rst_n low) clears the rule state and both valid flags.
//   When res_out stalls, non-final characters keep flowing; a final
//   character waits in the input register and char_in.ready drops only
//   once that register holds it and the result is still not taken.
// Depends on esc_pkg, esc_char_if, esc_res_if, esc_in_stage, esc_rules.
`include "assert_macros.svh"
module email_syntax_checker_core #(
    parameter int MAX_LEN = esc_pkg::MAX_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    esc_char_if.sink   char_in,
    esc_res_if.source  res_out
);
    import esc_pkg::*;

    stage_t stage;
    logic   adv;

    // Input register.
    esc_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_in),
        .adv     (adv),
        .stage   (stage)
    );

    // Rule evaluation and result register.
    esc_rules #(
        .MAX_LEN (MAX_LEN)
    ) u_rules (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .adv     (adv),
        .res_out (res_out)
    );

    // A held item that cannot move blocks the input channel.
    `ESC_ASSERT_NOW(a_hold_blocks, clk, rst_n, stage.valid && !adv, !char_in.ready)
    // A final character that moves on yields a result in the next cycle.
    `ESC_ASSERT_NEXT(a_last_gives_res, clk, rst_n, adv && stage.last, res_out.valid)
    // Only a final character can start a new result.
    `ESC_ASSERT_NOW(a_res_from_last, clk, rst_n, $rose(res_out.valid), $past(adv && stage.last))
endmodule
